FILE: hw/rtl/waypoint_heading_histogram_defines.svh
// Assertion macros shared by the waypoint heading histogram RTL.
// Each macro expects signals named clk and arst_n where it is used.
`ifndef WAYPOINT_HEADING_HISTOGRAM_DEFINES_SVH
`define WAYPOINT_HEADING_HISTOGRAM_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WHH_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WHH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/whh_pkg.sv
// Shared types, constants and tables for the waypoint heading histogram.
// No dependencies; used by every module of the block.
package whh_pkg;

	localparam int UNITS_DEF    = 10;
	localparam int UNITS_MAX    = 32;
	localparam int CORDIC_STEPS = 25;
	localparam int XW           = 34;
	localparam int ZW           = 28;
	localparam int CFG_IW       = 8;

	localparam logic signed [ZW-1:0] PI_Q24 = 28'sd52707179;

	localparam logic signed [ZW-1:0] ROT_Q24 [0:CORDIC_STEPS-1] = '{
		28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331, 28'sd1047214,
		28'sd524117, 28'sd262123, 28'sd131069, 28'sd65536, 28'sd32768,
		28'sd16384, 28'sd8192, 28'sd4096, 28'sd2048, 28'sd1024,
		28'sd512, 28'sd256, 28'sd128, 28'sd64, 28'sd32,
		28'sd16, 28'sd8, 28'sd4, 28'sd2, 28'sd1
	};

	typedef logic [32:0] wtab_t [0:UNITS_MAX-1];

	function automatic wtab_t whh_weights();
		longint w;
		wtab_t t;
		w = 64'sd1 <<< 32;
		for (int k = 0; k < UNITS_MAX; k++) begin
			t[k] = w[32:0];
			w = (w * 9 + 9) / 10;
		end
		return t;
	endfunction

	localparam wtab_t WEIGHT_TAB = whh_weights();

	typedef enum logic [CFG_IW-1:0] {
		REG_GOAL_X     = 8'd0,
		REG_GOAL_Y     = 8'd1,
		REG_GOAL_VALUE = 8'd2,
		REG_DEADLINE   = 8'd3
	} reg_idx_t;

	typedef struct packed {
		logic                 vld;
		logic                 act;
		logic                 zr;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic signed [15:0]   hd;
	} cord_t;

	typedef struct packed {
		logic       vld;
		logic       act;
		logic [8:0] center;
	} ang_t;

endpackage

FILE: hw/rtl/waypoint_heading_histogram.sv
// Top level of the waypoint heading histogram: registers, CORDIC, angle, emitter.
// Depends on whh_pkg, whh_cordic, whh_angle, whh_emit and the defines header.
//
// Channel | Dir | Handshake          | Payload
// s_      | in  | s_tvalid/s_tready  | position report, fix flag on s_tuser
// m_      | out | m_tvalid/m_tready  | bin beat, active on m_tuser, last on m_tlast
// cfg_    | in  | cfg_valid/cfg_ready| register index and data
//
// A report passes a 32-stage pipeline (1 front, 25 CORDIC, 6 angle) and then the emitter.
// The emitter sweeps the 2*UNITS-1 offsets, one per cycle unless stalled, then gives
// one closing beat; an inactive report gets only that beat. A new report enters in the
// closing beat. A stall at the result register halts the emitter, then the whole pipeline.
// Reset clears the registers to zero and empties the pipeline.
`include "waypoint_heading_histogram_defines.svh"
module waypoint_heading_histogram import whh_pkg::*; #(
	parameter int UNITS = UNITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [79:0]       s_tdata,   // now_time[31:0], pos_x, pos_y, heading
	input  logic              s_tuser,   // position_ok
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [31:0]       m_tdata,   // bin_index[8:0], bin_value[24:9], zero fill
	output logic              m_tuser,   // active
	output logic              m_tlast,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [31:0]       cfg_data
);

	logic signed [15:0] goal_x_q, goal_y_q;
	logic signed [23:0] goal_value_q;
	logic [31:0]        deadline_q;

	logic               en, emit_rdy;
	logic signed [16:0] dx, dy;
	logic               act;
	cord_t              cord;
	ang_t               ang;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q     <= '0;
			goal_y_q     <= '0;
			goal_value_q <= '0;
			deadline_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GOAL_X:     goal_x_q     <= cfg_data[15:0];
				REG_GOAL_Y:     goal_y_q     <= cfg_data[15:0];
				REG_GOAL_VALUE: goal_value_q <= cfg_data[23:0];
				REG_DEADLINE:   deadline_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		dx  = 17'(goal_x_q) - 17'($signed(s_tdata[47:32]));
		dy  = 17'(goal_y_q) - 17'($signed(s_tdata[63:48]));
		act = (s_tdata[31:0] < deadline_q) && s_tuser;
		en  = !ang.vld || emit_rdy;
	end

	assign s_tready = en;

	whh_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (s_tvalid),
		.in_act (act),
		.dx     (dx),
		.dy     (dy),
		.hd     ($signed(s_tdata[79:64])),
		.res    (cord)
	);

	whh_angle u_angle (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.c      (cord),
		.res    (ang)
	);

	whh_emit #(.UNITS(UNITS)) u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.in         (ang),
		.in_rdy     (emit_rdy),
		.goal_value (goal_value_q),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

	`WHH_ASSERT_NOW(a_inactive_beat, m_tvalid && !m_tuser, m_tlast && (m_tdata == 32'd0), "inactive beat must be a closing zero beat")
	`WHH_ASSERT_NOW(a_bin_range, m_tvalid && m_tuser, m_tdata[8:0] < 9'd360, "bin index out of range")
	`WHH_ASSERT_NOW(a_pipe_flow, !ang.vld, s_tready, "pipeline stalled without a waiting report")
	`WHH_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid, "result beat dropped while stalled")

endmodule

FILE: hw/rtl/whh_cordic.sv
// Pipelined vectoring CORDIC: one rotation per register stage.
// Depends on whh_pkg for the rotation table and the stage record.
module whh_cordic import whh_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  logic                in_act,
	input  logic signed [16:0]  dx,
	input  logic signed [16:0]  dy,
	input  logic signed [15:0]  hd,
	output cord_t               res
);

	cord_t st [0:CORDIC_STEPS];

	logic signed [XW-1:0] xs, ys;
	cord_t front;

	always_comb begin
		xs = XW'(dx) <<< 14;
		ys = XW'(dy) <<< 14;
		front.vld = in_vld;
		front.act = in_act;
		front.zr  = (dx == '0) && (dy == '0);
		front.hd  = hd;
		if (dx < 0) begin
			front.x = -xs;
			front.y = -ys;
			front.z = (dy >= 0) ? PI_Q24 : -PI_Q24;
		end else begin
			front.x = xs;
			front.y = ys;
			front.z = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st[0] <= '0;
		end else if (en) begin
			st[0] <= front;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
		logic signed [XW-1:0] xsh, ysh;
		assign xsh = st[i].x >>> i;
		assign ysh = st[i].y >>> i;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				st[i+1] <= '0;
			end else if (en) begin
				st[i+1] <= st[i];
				if (st[i].y >= 0) begin
					st[i+1].x <= st[i].x + ysh;
					st[i+1].y <= st[i].y - xsh;
					st[i+1].z <= st[i].z + ROT_Q24[i];
				end else begin
					st[i+1].x <= st[i].x - ysh;
					st[i+1].y <= st[i].y + xsh;
					st[i+1].z <= st[i].z - ROT_Q24[i];
				end
			end
		end
	end

	assign res = st[CORDIC_STEPS];

endmodule

FILE: hw/rtl/whh_angle.sv
// Converts the bearing and heading to degrees and folds it into the center bin.
// Depends on whh_pkg; fed by whh_cordic.
module whh_angle import whh_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  cord_t c,
	output ang_t  res
);

	localparam longint DIVISOR  = 31415;
	localparam longint NUM_OFS  = 64'sd360 * DIVISOR * (64'sd1 <<< 24);
	localparam longint RECIP    = (64'sd1 <<< 40) / DIVISOR;

	localparam logic signed [21:0] DEG_NUM  = 22'sd1800000;
	localparam logic signed [52:0] OFS      = 53'(NUM_OFS);
	localparam logic [25:0]        RECIP_C  = 26'(RECIP);
	localparam logic [14:0]        DIV_C    = 15'(DIVISOR);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic act_s1, act_s2, act_s3, act_s4, act_s5, act_s6;
	logic signed [30:0] diff_s1;
	logic signed [52:0] prod_s2;
	logic               neg_s3, neg_s4;
	logic [28:0]        m_s3, m_s4;
	logic [14:0]        q0_s4;
	logic signed [15:0] ang_s5;
	logic [8:0]         center_s6;

	logic signed [30:0] zsel;
	logic signed [52:0] prod;
	logic signed [52:0] num, anum;
	logic [54:0]        qprod;
	logic [29:0]        rem;
	logic [15:0]        q;
	logic signed [16:0] t;

	always_comb begin
		zsel  = c.zr ? '0 : 31'(c.z);
		prod  = diff_s1 * DEG_NUM;
		num   = prod_s2 + OFS;
		anum  = (num < 0) ? -num : num;
		qprod = 55'(m_s3) * 55'(RECIP_C);
		rem   = 30'(m_s4) - 30'(q0_s4) * 30'(DIV_C);
		q     = 16'(q0_s4) + ((rem >= 30'(DIV_C)) ? 16'd1 : 16'd0);
		t     = 17'sd540 - 17'(ang_s5);
		for (int i = 0; i < 5; i++) begin
			if (t < 0) begin
				t = t + 17'sd360;
			end else if (t >= 17'sd360) begin
				t = t - 17'sd360;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6} <= '0;
			{act_s1, act_s2, act_s3, act_s4, act_s5, act_s6} <= '0;
		end else if (en) begin
			vld_s1 <= c.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			act_s1 <= c.act;
			act_s2 <= act_s1;
			act_s3 <= act_s2;
			act_s4 <= act_s3;
			act_s5 <= act_s4;
			act_s6 <= act_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s1   <= zsel - (31'(c.hd) <<< 12);
			prod_s2   <= prod;
			neg_s3    <= num < 0;
			m_s3      <= anum[52:24];
			neg_s4    <= neg_s3;
			m_s4      <= m_s3;
			q0_s4     <= qprod[54:40];
			ang_s5    <= neg_s4 ? -q : q;
			center_s6 <= t[8:0];
		end
	end

	assign res.vld    = vld_s6;
	assign res.act    = act_s6;
	assign res.center = center_s6;

endmodule

FILE: hw/rtl/whh_emit.sv
// Sweeps the bin offsets of one report and drives the result register.
// Depends on whh_pkg for the weight table; fed by whh_angle.
module whh_emit import whh_pkg::*; #(
	parameter int UNITS = UNITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ang_t               in,
	output logic               in_rdy,
	input  logic signed [23:0] goal_value,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [31:0]        m_tdata,
	output logic               m_tuser,
	output logic               m_tlast
);

	localparam int OW = $clog2(UNITS) + 2;
	localparam int KW = OW - 1;
	localparam logic signed [OW-1:0] OFF_FIRST = OW'(-(UNITS - 1));
	localparam logic signed [OW-1:0] OFF_LAST  = OW'(UNITS - 1);

	logic                busy_q, done_q, pend_vld_q;
	logic [8:0]          center_q, pend_idx_q, idx_q;
	logic signed [OW-1:0] off_q;
	logic [15:0]         pend_val_q, val_q;
	logic                act_q, last_q;

	logic [OW-1:0]       kk;
	logic [KW-1:0]       k;
	logic [32:0]         w;
	logic                gneg;
	logic [23:0]         gmag;
	logic [55:0]         prod;
	logic [15:0]         vmag, val;
	logic                nz;
	logic signed [10:0]  s;
	logic [8:0]          idx;
	logic                out_free, step, flush;

	always_comb begin
		kk   = (off_q < 0) ? OW'(-off_q) : OW'(off_q);
		k    = kk[KW-1:0];
		w    = WEIGHT_TAB[k];
		gneg = goal_value[23];
		gmag = gneg ? 24'(-goal_value) : 24'(goal_value);
		prod = (k == '0) ? {gmag, 32'b0} : 56'(gmag) * 56'(w[31:0]);
		vmag = prod[55:40];
		nz   = vmag != '0;
		if (!gneg) begin
			val = (vmag > 16'd32767) ? 16'h7fff : vmag;
		end else begin
			val = (vmag > 16'd32768) ? 16'h8000 : 16'(-vmag);
		end
		s = 11'({2'b00, center_q}) + 11'(off_q);
		if (s < 0) begin
			s = s + 11'sd360;
		end else if (s >= 11'sd360) begin
			s = s - 11'sd360;
		end
		idx = s[8:0];
		out_free = !m_tvalid || m_tready;
		step     = busy_q && !done_q && out_free;
		flush    = busy_q && done_q && out_free;
		in_rdy   = !busy_q || flush;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			done_q     <= 1'b0;
			pend_vld_q <= 1'b0;
			m_tvalid   <= 1'b0;
			off_q      <= '0;
			center_q   <= '0;
			pend_idx_q <= '0;
			pend_val_q <= '0;
			act_q      <= 1'b0;
			last_q     <= 1'b0;
			idx_q      <= '0;
			val_q      <= '0;
		end else begin
			if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			if (step) begin
				if (nz) begin
					if (pend_vld_q) begin
						m_tvalid <= 1'b1;
						act_q    <= 1'b1;
						last_q   <= 1'b0;
						idx_q    <= pend_idx_q;
						val_q    <= pend_val_q;
					end
					pend_vld_q <= 1'b1;
					pend_idx_q <= idx;
					pend_val_q <= val;
				end
				if (off_q == OFF_LAST) begin
					done_q <= 1'b1;
				end else begin
					off_q <= off_q + OW'(1);
				end
			end
			if (flush) begin
				m_tvalid <= 1'b1;
				act_q    <= pend_vld_q;
				last_q   <= 1'b1;
				idx_q    <= pend_vld_q ? pend_idx_q : '0;
				val_q    <= pend_vld_q ? pend_val_q : '0;
				busy_q   <= 1'b0;
			end
			if (in.vld && in_rdy) begin
				busy_q     <= 1'b1;
				done_q     <= !in.act;
				center_q   <= in.center;
				off_q      <= OFF_FIRST;
				pend_vld_q <= 1'b0;
			end
		end
	end

	assign m_tdata = {7'b0, val_q, idx_q};
	assign m_tuser = act_q;
	assign m_tlast = last_q;

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for waypoint_heading_histogram: directed and random reports,
// a bit-exact bearing and bin predictor, random stalls on both streams. Needs whh_pkg.
module tb_top;
	import whh_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE = 80;
	localparam logic [CFG_IW-1:0] REG_SPARE = 8'hA5;

	typedef struct {
		logic [31:0]        now;
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic signed [15:0] hd;
		logic               ok;
	} report_t;

	typedef struct {
		logic               act;
		logic [8:0]         idx;
		logic signed [15:0] val;
		logic               last;
	} bin_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [79:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic m_tuser;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	logic signed [15:0] goal_x_q = '0;
	logic signed [15:0] goal_y_q = '0;
	logic signed [23:0] goal_val_q = '0;
	logic [31:0] deadline_q = '0;

	report_t pending_reports[$];
	report_t cur_report;
	bin_t expected_bins[$];
	int errors = 0;
	int reports_sent = 0;
	int bins_seen = 0;
	int active_seen = 0;
	int cycles = 0;
	bit no_idle = 1'b0;
	bit held_off = 1'b0;

	always #4 clk = ~clk;

	waypoint_heading_histogram dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic longint bearing(longint dx, longint dy);
		longint rot[CORDIC_STEPS] = '{13176795, 7778716, 4110060, 2086331, 1047214,
			524117, 262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024,
			512, 256, 128, 64, 32, 16, 8, 4, 2, 1};
		longint x, y, z, xs, ys;
		x = dx * 16384;
		y = dy * 16384;
		z = 0;
		if (dx == 0 && dy == 0)
			return 0;
		if (dx < 0) begin
			z = (dy >= 0) ? 64'sd52707179 : -64'sd52707179;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys; y -= xs; z += rot[i];
			end else begin
				x -= ys; y += xs; z -= rot[i];
			end
		end
		return z;
	endfunction

	function automatic longint bin_weight(longint g, int k);
		longint w, mag, v;
		w = 64'sd1 <<< 32;
		mag = (g < 0) ? -g : g;
		for (int i = 0; i < k; i++)
			w = (w * 9 + 9) / 10;
		v = (mag * w) >>> 40;
		if (g < 0)
			v = -v;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v;
	endfunction

	function automatic void predict_bins(report_t r);
		longint den, diff, ang, center, v, idx;
		bin_t b;
		int n;
		n = 0;
		den = 64'sd31415 * (64'sd1 <<< 24);
		if (!(r.now < deadline_q) || !r.ok) begin
			expected_bins.push_back('{1'b0, 9'd0, 16'sd0, 1'b1});
			return;
		end
		diff = bearing(longint'(goal_x_q) - longint'(r.px), longint'(goal_y_q) - longint'(r.py))
			- longint'(r.hd) * 4096;
		ang = (diff * 1800000 + 360 * den) / den;
		center = (540 - ang) % 360;
		if (center < 0)
			center += 360;
		for (int off = -(UNITS_DEF - 1); off <= UNITS_DEF - 1; off++) begin
			v = bin_weight(longint'(goal_val_q), off < 0 ? -off : off);
			if (v != 0) begin
				idx = (center + off) % 360;
				if (idx < 0)
					idx += 360;
				b.act = 1'b1;
				b.idx = idx[8:0];
				b.val = v[15:0];
				b.last = 1'b0;
				expected_bins.push_back(b);
				n++;
			end
		end
		if (n == 0)
			expected_bins.push_back('{1'b0, 9'd0, 16'sd0, 1'b1});
		else
			expected_bins[$].last = 1'b1;
	endfunction

	// Source side: the front of the queue is offered until it is taken.
	always @(posedge clk or negedge arst_n) begin
		int gap;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_bins(cur_report);
				void'(pending_reports.pop_front());
				reports_sent++;
			end
			if (!(s_tvalid && !s_tready)) begin
				if (gap > 0) begin
					gap--;
					s_tvalid <= 1'b0;
				end else if (pending_reports.size() > 0) begin
					cur_report = pending_reports[0];
					s_tdata <= {cur_report.hd, cur_report.py, cur_report.px, cur_report.now};
					s_tuser <= cur_report.ok;
					s_tvalid <= 1'b1;
					gap = pick_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Sink side: random stalls, plus one long hold-off once traffic is flowing.
	always @(posedge clk or negedge arst_n) begin
		int hold;
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold = 0;
		end else begin
			if (!held_off && reports_sent >= 40) begin
				held_off = 1'b1;
				hold = 400;
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else begin
				hold = pick_gap();
				m_tready <= (hold == 0);
			end
		end
	end

	always @(posedge clk) begin
		bin_t e;
		if (arst_n && m_tvalid && m_tready) begin
			bins_seen++;
			if (m_tuser)
				active_seen++;
			if (expected_bins.size() == 0) begin
				$error("unexpected result beat: bin_index %0d", m_tdata[8:0]);
				errors++;
			end else begin
				e = expected_bins.pop_front();
				if (m_tuser !== e.act) begin
					$error("active: expected %0d, got %0d", e.act, m_tuser);
					errors++;
				end
				if (m_tdata[8:0] !== e.idx) begin
					$error("bin_index: expected %0d, got %0d", e.idx, m_tdata[8:0]);
					errors++;
				end
				if ($signed(m_tdata[24:9]) !== e.val) begin
					$error("bin_value: expected %0d, got %0d", e.val, $signed(m_tdata[24:9]));
					errors++;
				end
				if (m_tlast !== e.last) begin
					$error("last: expected %0d, got %0d", e.last, m_tlast);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IW-1:0] idx, logic [31:0] data);
		@(posedge clk);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_GOAL_X:     goal_x_q = data[15:0];
			REG_GOAL_Y:     goal_y_q = data[15:0];
			REG_GOAL_VALUE: goal_val_q = data[23:0];
			REG_DEADLINE:   deadline_q = data;
			default: ;
		endcase
	endtask

	task automatic set_goal(int gx, int gy, int gv, logic [31:0] dl);
		write_reg(REG_GOAL_X, gx);
		write_reg(REG_GOAL_Y, gy);
		write_reg(REG_GOAL_VALUE, gv);
		write_reg(REG_DEADLINE, dl);
	endtask

	task automatic add_report(logic [31:0] now, int px, int py, int hd, logic ok);
		pending_reports.push_back('{now, px[15:0], py[15:0], hd[15:0], ok});
	endtask

	task automatic drain();
		while (pending_reports.size() > 0 || s_tvalid || expected_bins.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic int rand_goal_value();
		int r;
		r = $urandom_range(0, 3);
		if (r == 0)
			return $urandom_range(0, 4000) - 2000;
		if (r == 1)
			return $urandom_range(0, 200000) - 100000;
		return $signed({$urandom} << 8) >>> 8;
	endfunction

	initial begin
		logic [31:0] dl, now;
		int gx, gy, px, py;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Reset values: deadline 0 makes every report inactive.
		add_report(32'd0, 0, 0, 0, 1'b1);
		add_report(32'hFFFFFFFF, 100, -100, 0, 1'b1);
		drain();

		write_reg(REG_SPARE, 32'hFFFFFFFF);
		set_goal(0, 0, 24'h7FFFFF, 32'hFFFFFFFF);
		add_report(32'd0, 0, 0, 0, 1'b1);
		add_report(32'hFFFFFFFE, 32767, 32767, 32767, 1'b1);
		add_report(32'hFFFFFFFF, 5, 5, 0, 1'b1);
		add_report(32'd5, -32768, -32768, -32768, 1'b1);
		add_report(32'd6, 1000, -1, 0, 1'b1);
		add_report(32'd7, 1000, 1, 0, 1'b1);
		add_report(32'd8, 1000, 0, 0, 1'b1);
		add_report(32'd9, 0, 1000, 12868, 1'b1);
		add_report(32'd10, 50, 50, 0, 1'b0);
		drain();

		set_goal(-32768, 32767, -24'sd8388608, 32'd1000);
		add_report(32'd999, 32767, -32768, -32768, 1'b1);
		add_report(32'd1000, 0, 0, 0, 1'b1);
		add_report(32'd0, -32768, 32767, 32767, 1'b1);
		add_report(32'd1, 0, -32768, -6434, 1'b1);
		drain();

		set_goal(32767, -32768, 300, 32'h80000000);
		add_report(32'd1, 0, 0, 0, 1'b1);
		add_report(32'd2, 32767, -32768, 0, 1'b1);
		add_report(32'd3, -32768, 32767, 20000, 1'b1);
		drain();
		set_goal(100, 100, 0, 32'hFFFFFFFF);
		add_report(32'd1, 0, 0, 0, 1'b1);
		add_report(32'd2, -5, 7, 100, 1'b1);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			no_idle = (ph == 2);
			gx = $signed($urandom_range(0, 65535) - 32768);
			gy = $signed($urandom_range(0, 65535) - 32768);
			dl = ($urandom_range(0, 3) == 0) ? $urandom : 32'hF0000000 | $urandom;
			set_goal(gx, gy, rand_goal_value(), dl);
			for (int i = 0; i < 55; i++) begin
				now = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, dl);
				if ($urandom_range(0, 4) == 0) begin
					px = gx + $urandom_range(0, 6) - 3;
					py = gy + $urandom_range(0, 6) - 3;
				end else begin
					px = $urandom;
					py = $urandom;
				end
				add_report(now, px, py, $urandom, $urandom_range(0, 15) != 0);
			end
			drain();
		end

		$display("Covered %0d position reports, %0d result beats (%0d active bins),",
			reports_sent, bins_seen, active_seen);
		$display("across several goal settings, with random stalls and a long sink hold-off.");
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/whh_pkg.sv
hw/rtl/whh_cordic.sv
hw/rtl/whh_angle.sv
hw/rtl/whh_emit.sv
hw/rtl/waypoint_heading_histogram.sv
verif/tb_top.sv
